// ----- hw/rtl/rupk_pkg.sv -----
package rupk_pkg;

   // fixed field widths
   localparam int NET_W      = 32;
   localparam int METRIC_W   = 16;
   localparam int CAP_W      = 7;
   localparam int HOP_W      = 16;
   localparam int REQ_DATA_W = 88;
   localparam int RSP_DATA_W = 48;
   localparam int ENTRY_W    = NET_W + METRIC_W;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 1;

   localparam logic [CSR_IDX_W-1:0] REG_CAPACITY = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_HOP_INF  = 1'b1;

   localparam logic [CAP_W-1:0] CAPACITY_RESET = 7'd64;
   localparam logic [HOP_W-1:0] HOP_INF_RESET  = 16'd16;

   // request kinds
   localparam logic KIND_ROUTE = 1'b0;
   localparam logic KIND_FLUSH = 1'b1;

   // one packet buffer entry
   typedef struct packed {
      logic [METRIC_W-1:0] metric;
      logic [NET_W-1:0]    net;
   } entry_type;

endpackage

// ----- hw/rtl/rupk_ram.sv -----
module rupk_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 64
) (
   input  logic                                          clock,
   input  logic                                          wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]                              wr_data,
   input  logic                                          rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
   output logic [WIDTH-1:0]                              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/route_update_packer_unit.sv -----
// Route update packer. Takes a stream of route entries (host table first, then
// net table) on the req_ channel and packs them into routing-response packets
// delivered on the rsp_ channel, one word per packet entry with tlast on the
// final entry. Each route entry advertises the router's net for a host route
// without a gateway and the destination net otherwise, at the stored metric
// plus one saturated at hop_infinity. A net already present in the packet
// keeps the smaller metric; a new net is appended. A full packet (at
// packet_capacity, 0 acting as 1, clipped to MAX_ENTRIES) goes out just before
// the next route entry, and an end word (tuser high) flushes a non-empty
// packet. The packet lives in a single-port-read buffer memory, so a route
// entry reads and compares the held entries one at a time (read state, then
// compare state), and an emitted packet reads each entry in turn and waits
// in the load state on any output stall. The last result stays in the
// output register while the next word is taken. No clearing pass is needed
// after reset: only entries below the fill count are ever read.
module route_update_packer_unit #(
   parameter int MAX_ENTRIES = 64
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // request channel
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // host_route [0], via_gateway [1], dest_net [33:2], router_net [65:34],
   // route_metric [81:66], zero pad [87:82]
   input  logic [rupk_pkg::REQ_DATA_W-1:0]        req_tdata,
   // kind [0]
   input  logic                                   req_tuser,
   // response channel
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // entry_net [31:0], entry_metric [47:32]
   output logic [rupk_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   output logic                                   rsp_tlast,
   // configuration port
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [rupk_pkg::CSR_ADDR_W-1:0]        csr_paddr,
   input  logic [rupk_pkg::CSR_DATA_W-1:0]        csr_pwdata,
   output logic [rupk_pkg::CSR_DATA_W-1:0]        csr_prdata,
   output logic                                   csr_pready
);

   import rupk_pkg::*;

   localparam int AW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW    = $clog2(MAX_ENTRIES + 1);
   localparam int CMP_W = (CW > CAP_W) ? CW : CAP_W;

   // sequencer states
   typedef enum logic [4:0] {
      ST_IDLE     = 5'b00001,
      ST_EMIT_RD  = 5'b00010,
      ST_EMIT_LD  = 5'b00100,
      ST_SCAN_RD  = 5'b01000,
      ST_SCAN_CMP = 5'b10000
   } state_type;

   // append is folded into a flag so the enum stays small
   state_type           state_ff, state_in;
   logic                append_ff, append_in;   // an append is due in idle
   logic [CW-1:0]       fill_ff, fill_in;
   logic [AW-1:0]       idx_ff, idx_in;
   logic                pend_ff, pend_in;       // route entry waits behind an emit
   logic [NET_W-1:0]    net_ff, net_in;
   logic [METRIC_W-1:0] met_ff, met_in;

   logic [CAP_W-1:0]    cap_ff;
   logic [HOP_W-1:0]    inf_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [NET_W-1:0]    rsp_net_ff, rsp_net_in;
   logic [METRIC_W-1:0] rsp_met_ff, rsp_met_in;
   logic                rsp_last_ff, rsp_last_in;

   // request fields
   logic                req_kind;
   logic                req_host;
   logic                req_gw;
   logic [NET_W-1:0]    req_dest;
   logic [NET_W-1:0]    req_router;
   logic [METRIC_W-1:0] req_metric;
   logic                req_accept;

   logic [METRIC_W:0]   met_sum;
   logic [METRIC_W-1:0] met_adv;
   logic                pkt_full;
   logic                idx_last;
   logic                rsp_free;
   logic                csr_write;
   logic [CSR_IDX_W-1:0] csr_idx;

   // buffer memory
   logic                ram_we;
   logic [AW-1:0]       ram_wr_addr;
   entry_type           ram_wr_data;
   logic                ram_rd_en;
   logic [ENTRY_W-1:0]  ram_rd_raw;
   entry_type           ram_rd_data;

   assign req_kind   = req_tuser;
   assign req_host   = req_tdata[0];
   assign req_gw     = req_tdata[1];
   assign req_dest   = req_tdata[33:2];
   assign req_router = req_tdata[65:34];
   assign req_metric = req_tdata[81:66];

   assign req_tready = (state_ff == ST_IDLE) && !append_ff;
   assign req_accept = req_tvalid && req_tready;

   // advertised metric, saturated at the unreachable value
   assign met_sum = {1'b0, req_metric} + {{METRIC_W{1'b0}}, 1'b1};
   assign met_adv = (met_sum > {1'b0, inf_ff}) ? inf_ff : met_sum[METRIC_W-1:0];

   // fill at or above the effective capacity (capacity 0 acts as 1)
   assign pkt_full = (fill_ff != '0) &&
                     ((CMP_W'(fill_ff) >= CMP_W'(cap_ff)) ||
                      (fill_ff >= CW'(MAX_ENTRIES)));

   assign idx_last = (CW'(idx_ff) + CW'(1)) == fill_ff;
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   assign ram_rd_data = entry_type'(ram_rd_raw);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      append_in    = append_ff;
      fill_in      = fill_ff;
      idx_in       = idx_ff;
      pend_in      = pend_ff;
      net_in       = net_ff;
      met_in       = met_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_net_in   = rsp_net_ff;
      rsp_met_in   = rsp_met_ff;
      rsp_last_in  = rsp_last_ff;
      ram_we       = 1'b0;
      ram_wr_addr  = idx_ff;
      ram_wr_data  = '{metric: met_ff, net: net_ff};
      ram_rd_en    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (append_ff) begin
               // new net goes at the end of the packet
               append_in = 1'b0;
               if (fill_ff < CW'(MAX_ENTRIES)) begin
                  ram_we      = 1'b1;
                  ram_wr_addr = AW'(fill_ff);
                  fill_in     = fill_ff + CW'(1);
               end
            end else if (req_accept) begin
               idx_in = '0;
               if (req_kind == KIND_FLUSH) begin
                  if (fill_ff != '0) begin
                     pend_in  = 1'b0;
                     state_in = ST_EMIT_RD;
                  end
               end else begin
                  net_in = (req_host && !req_gw) ? req_router : req_dest;
                  met_in = met_adv;
                  if (pkt_full) begin
                     pend_in  = 1'b1;
                     state_in = ST_EMIT_RD;
                  end else if (fill_ff == '0) begin
                     append_in = 1'b1;
                  end else begin
                     state_in = ST_SCAN_RD;
                  end
               end
            end
         end
         ST_EMIT_RD: begin
            ram_rd_en = 1'b1;
            state_in  = ST_EMIT_LD;
         end
         ST_EMIT_LD: begin
            // memory read data holds until the output register frees up
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_net_in   = ram_rd_data.net;
               rsp_met_in   = ram_rd_data.metric;
               rsp_last_in  = idx_last;
               if (idx_last) begin
                  fill_in   = '0;
                  append_in = pend_ff;
                  state_in  = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + AW'(1);
                  state_in = ST_EMIT_RD;
               end
            end
         end
         ST_SCAN_RD: begin
            ram_rd_en = 1'b1;
            state_in  = ST_SCAN_CMP;
         end
         ST_SCAN_CMP: begin
            if (ram_rd_data.net == net_ff) begin
               // duplicate: keep the smaller metric
               if (met_ff < ram_rd_data.metric) begin
                  ram_we = 1'b1;
               end
               state_in = ST_IDLE;
            end else if (idx_last) begin
               append_in = 1'b1;
               state_in  = ST_IDLE;
            end else begin
               idx_in   = idx_ff + AW'(1);
               state_in = ST_SCAN_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         append_ff    <= 1'b0;
         fill_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         append_ff    <= append_in;
         fill_ff      <= fill_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      net_ff      <= net_in;
      met_ff      <= met_in;
      rsp_net_ff  <= rsp_net_in;
      rsp_met_ff  <= rsp_met_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_met_ff, rsp_net_ff};
   assign rsp_tlast  = rsp_last_ff;

   // configuration registers, decoded on the word address bit
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAPACITY_RESET;
         inf_ff <= HOP_INF_RESET;
      end else if (csr_write) begin
         unique case (csr_idx)
            REG_CAPACITY: cap_ff <= csr_pwdata[CAP_W-1:0];
            REG_HOP_INF:  inf_ff <= csr_pwdata[HOP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_CAPACITY: csr_prdata = CSR_DATA_W'(cap_ff);
         REG_HOP_INF:  csr_prdata = CSR_DATA_W'(inf_ff);
         default:      csr_prdata = '0;
      endcase
   end

   // packet buffer: net and metric of each entry in one word
   rupk_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(MAX_ENTRIES)
   ) u_buf (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(idx_ff),
      .rd_data(ram_rd_raw)
   );

   // checks
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(MAX_ENTRIES))
      else $error("fill count beyond buffer depth");

   a_emit_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT_RD) |-> (fill_ff != '0))
      else $error("emit started on an empty packet");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT_LD && rsp_free && idx_last) |=> (fill_ff == '0))
      else $error("packet not cleared after final entry");

   a_scan_below_fill: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN_RD || state_ff == ST_EMIT_RD) |-> (CW'(idx_ff) < fill_ff))
      else $error("buffer read at or above fill count");

   a_append_room: assert property (@(posedge clock) disable iff (reset)
      (append_ff && state_ff == ST_IDLE) |-> (fill_ff < CW'(MAX_ENTRIES)))
      else $error("append into a full buffer");

endmodule

// ----- bench/route_update_packer_checker.sv -----
module route_update_packer_checker #(
   parameter int MAX_ENTRIES = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   // host_route [0], via_gateway [1], dest_net [33:2], router_net [65:34],
   // route_metric [81:66], zero pad [87:82]
   input  logic [rupk_pkg::REQ_DATA_W-1:0]   req_tdata,
   // kind [0]
   input  logic                              req_tuser,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // entry_net [31:0], entry_metric [47:32]
   input  logic [rupk_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                              rsp_tlast,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [rupk_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [rupk_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   input  logic                              csr_pready,
   output int                                pending_count,
   output int                                error_count
);
   import rupk_pkg::*;

   localparam int PRINT_CAP = 50;

   typedef struct packed {
      logic [NET_W-1:0]    net;
      logic [METRIC_W-1:0] metric;
      logic                last;
   } advert_type;

   advert_type          advert_q[$];
   logic [NET_W-1:0]    held_net [MAX_ENTRIES];
   logic [METRIC_W-1:0] held_metric [MAX_ENTRIES];
   int                  held_count;
   logic [CAP_W-1:0]    capacity_reg;
   logic [HOP_W-1:0]    hop_inf_reg;

   task automatic report(input string msg);
      if (error_count < PRINT_CAP) begin
         $display("[%0t] mismatch: %s", $realtime, msg);
      end
      error_count++;
   endtask

   function automatic int usable_capacity();
      int c;
      c = int'(capacity_reg);
      if (c < 1) c = 1;
      if (c > MAX_ENTRIES) c = MAX_ENTRIES;
      return c;
   endfunction

   // whole held packet goes out, last flag on its final entry
   task automatic ship_packet();
      advert_type a;
      for (int i = 0; i < held_count; i++) begin
         a.net    = held_net[i];
         a.metric = held_metric[i];
         a.last   = (i == held_count - 1);
         advert_q.push_back(a);
      end
      held_count = 0;
   endtask

   task automatic absorb_word(input logic [REQ_DATA_W-1:0] data, input logic kind);
      logic             host;
      logic             gw;
      logic [NET_W-1:0] net;
      logic [16:0]      adv;
      bit               merged;
      host   = data[0];
      gw     = data[1];
      adv    = {1'b0, data[81:66]} + 17'd1;
      merged = 1'b0;
      if (kind == KIND_FLUSH) begin
         if (held_count != 0) ship_packet();
      end else begin
         if (held_count >= usable_capacity()) ship_packet();
         net = (host && !gw) ? data[65:34] : data[33:2];
         if (adv > {1'b0, hop_inf_reg}) adv = {1'b0, hop_inf_reg};
         for (int i = 0; i < held_count; i++) begin
            if (!merged && held_net[i] == net) begin
               merged = 1'b1;
               if (adv[METRIC_W-1:0] < held_metric[i]) held_metric[i] = adv[METRIC_W-1:0];
            end
         end
         if (!merged && held_count < MAX_ENTRIES) begin
            held_net[held_count]    = net;
            held_metric[held_count] = adv[METRIC_W-1:0];
            held_count++;
         end
      end
   endtask

   task automatic check_word(input logic [RSP_DATA_W-1:0] data, input logic last);
      advert_type want;
      if (advert_q.size() == 0) begin
         report($sformatf("word with nothing expected: net %h metric %0d last %b",
                          data[NET_W-1:0], data[NET_W +: METRIC_W], last));
      end else begin
         want = advert_q.pop_front();
         if (data[NET_W-1:0] !== want.net)
            report($sformatf("entry_net %h, expected %h", data[NET_W-1:0], want.net));
         if (data[NET_W +: METRIC_W] !== want.metric)
            report($sformatf("entry_metric %0d, expected %0d (net %h)",
                             data[NET_W +: METRIC_W], want.metric, want.net));
         if (last !== want.last)
            report($sformatf("last %b, expected %b (net %h)", last, want.last, want.net));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         held_count   = 0;
         capacity_reg = CAPACITY_RESET;
         hop_inf_reg  = HOP_INF_RESET;
         advert_q.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[CSR_ADDR_W-1:2] == REG_CAPACITY) capacity_reg = csr_pwdata[CAP_W-1:0];
            else if (csr_paddr[CSR_ADDR_W-1:2] == REG_HOP_INF) hop_inf_reg = csr_pwdata[HOP_W-1:0];
         end
         if (req_tvalid && req_tready) absorb_word(req_tdata, req_tuser);
         if (rsp_tvalid && rsp_tready) check_word(rsp_tdata, rsp_tlast);
      end
      pending_count <= advert_q.size();
   end

endmodule

// ----- bench/tb_top.sv -----
module tb_top;
   import rupk_pkg::*;

   // a route entry scans up to a full packet, a read and a compare per held entry
   localparam int SETTLE_CYCLES = 160;
   localparam int CYCLE_LIMIT   = 1000000;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;
   logic                  req_tuser   = KIND_ROUTE;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int                    mismatch_count;
   int                    words_owed;
   int                    cycle_count = 0;
   // stretches of back-to-back words on each side
   int                    req_rush = 0;
   int                    rsp_rush = 0;
   // small set of nets so that merges into a held packet happen often
   logic [NET_W-1:0]      net_pool [8];

   route_update_packer_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   route_update_packer_checker u_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_pready    (csr_pready),
      .pending_count (words_owed),
      .error_count   (mismatch_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // hard stop in case the block hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // idle cycles before the next word, none while a rush lasts
   function automatic int pick_gap(input int rush);
      if (rush > 0) return 0;
      return $urandom_range(0, 14);
   endfunction

   // request word layout: pad, metric, router net, dest net, gateway, host
   function automatic logic [REQ_DATA_W-1:0] route_bits(input logic host, input logic gw,
                                                        input logic [NET_W-1:0] dnet,
                                                        input logic [NET_W-1:0] rnet,
                                                        input logic [METRIC_W-1:0] metric);
      return {{(REQ_DATA_W - 82){1'b0}}, metric, rnet, dnet, gw, host};
   endfunction

   function automatic logic [NET_W-1:0] pick_net(input int pool_pct);
      if ($urandom_range(0, 99) < pool_pct) return net_pool[3'($urandom_range(0, 7))];
      return $urandom;
   endfunction

   // small hop counts and zero, the top of the range hit often, else any value
   function automatic logic [METRIC_W-1:0] pick_metric();
      case ($urandom_range(0, 4))
         0: return METRIC_W'($urandom_range(0, 20));
         1: return '0;
         2: return METRIC_W'(16'hFFFF - $urandom_range(0, 1));
         default: return METRIC_W'($urandom_range(0, 65535));
      endcase
   endfunction

   // one word on the request channel; valid stays high across back-to-back words
   task automatic send_word(input logic kind, input logic [REQ_DATA_W-1:0] data);
      int gap;
      gap = pick_gap(req_rush);
      if (req_rush > 0) req_rush--;
      else if ($urandom_range(0, 19) == 0) req_rush = $urandom_range(8, 30);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= kind;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_route(input logic host, input logic gw, input logic [NET_W-1:0] dnet,
                             input logic [NET_W-1:0] rnet, input logic [METRIC_W-1:0] metric);
      send_word(KIND_ROUTE, route_bits(host, gw, dnet, rnet, metric));
   endtask

   // end-of-tables word; the other fields carry junk that must be ignored
   task automatic send_flush();
      send_word(KIND_FLUSH, route_bits(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                       $urandom, $urandom,
                                       METRIC_W'($urandom_range(0, 65535))));
   endtask

   // hold the sender until every predicted word has come out; with
   // after_scan also cover a route entry still scanning with no output
   task automatic settle(input bit after_scan);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (words_owed != 0) @(posedge clock);
      if (after_scan) repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // setup then access; transfers chain without dropping psel
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
   endtask

   task automatic set_config(input logic [CAP_W-1:0] cap, input logic [HOP_W-1:0] hop);
      settle(1'b1);
      csr_write(REG_CAPACITY, CSR_DATA_W'(cap));
      csr_write(REG_HOP_INF, CSR_DATA_W'(hop));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // random stretch under one setting; pool_pct steers how often nets repeat
   task automatic run_phase(input logic [CAP_W-1:0] cap, input logic [HOP_W-1:0] hop,
                            input int count, input int pool_pct, input int flush_pct);
      set_config(cap, hop);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 24) == 0) settle(1'b0);
         if ($urandom_range(0, 99) < flush_pct) send_flush();
         else send_route(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         pick_net(pool_pct), pick_net(pool_pct), pick_metric());
      end
   endtask

   // result side: random stalls per word, with rushes of steady ready
   initial begin : rsp_side
      int stall;
      forever begin
         stall = pick_gap(rsp_rush);
         if (rsp_rush > 0) rsp_rush--;
         else if ($urandom_range(0, 19) == 0) rsp_rush = $urandom_range(8, 40);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   initial begin
      net_pool[0] = '0;
      net_pool[1] = '1;
      for (int i = 2; i < 8; i++) net_pool[i] = $urandom;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset settings: capacity 64, infinity 16
      send_flush();                                        // nothing held, no output
      send_route(1'b0, 1'b0, 32'h0, 32'hFFFF_FFFF, 16'd0); // dest net, metric 1
      send_route(1'b1, 1'b0, 32'h1234_5678, 32'hFFFF_FFFF, 16'hFFFF); // router net, saturates
      send_route(1'b1, 1'b1, 32'hFFFF_FFFF, 32'h0, 16'd5); // gateway host route, merge lower
      send_route(1'b0, 1'b1, 32'h0, 32'h5555_AAAA, 16'd14); // merge, higher metric kept out
      send_route(1'b1, 1'b0, 32'hDEAD_BEEF, 32'h0, 16'd15); // merge at exactly infinity
      send_route(1'b0, 1'b0, 32'hAAAA_5555, 32'h0, 16'd16); // one past infinity
      send_flush();                                        // three entries out
      send_flush();                                        // empty again

      // two-entry packets, widest infinity
      set_config(7'd2, 16'hFFFF);
      send_route(1'b0, 1'b0, 32'd1, 32'd9, 16'hFFFF);      // saturates at top of range
      send_route(1'b0, 1'b0, 32'd2, 32'd9, 16'hFFFE);      // lands exactly on infinity
      send_route(1'b0, 1'b0, 32'd1, 32'd9, 16'd0);         // full packet goes before merge
      send_route(1'b0, 1'b1, 32'd3, 32'd9, 16'd7);         // packet left full and held

      // capacity zero acts as one and drops below the held count; zero infinity
      set_config(7'd0, 16'd0);
      send_route(1'b0, 1'b0, 32'd3, 32'd1, 16'd9);         // held pair goes out whole
      send_route(1'b1, 1'b0, 32'd7, 32'd3, 16'd200);       // same net, still emitted first
      send_flush();

      run_phase(7'd1, 16'd1, 16, 70, 10);
      run_phase(7'd64, 16'd16, 70, 0, 0);                  // fills one whole packet
      run_phase(7'd127, 16'hFFFF, 16, 60, 15);             // above the buffer depth
      run_phase(CAP_W'($urandom_range(0, 127)), HOP_W'($urandom_range(0, 65535)), 16, 50, 15);
      run_phase(CAP_W'($urandom_range(3, 10)), HOP_W'($urandom_range(0, 40)), 16, 60, 15);
      send_flush();

      settle(1'b1);
      if (mismatch_count == 0 && words_owed == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ----- files.f -----
hw/rtl/rupk_pkg.sv
hw/rtl/rupk_ram.sv
hw/rtl/route_update_packer_unit.sv
bench/route_update_packer_checker.sv
bench/tb_top.sv
